>>> rtl/arc_pkg.sv
// Aspect ratio converter package: divider widths, request/response structs,
// ratio constants and the state and match codes used by the sequencer.
// No dependencies.
package arc_pkg;

	localparam int DIV_NUM_W = 48;
	localparam int DIV_DEN_W = 32;
	localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

	localparam logic [15:0] K_4    = 16'd4;
	localparam logic [15:0] K_3    = 16'd3;
	localparam logic [15:0] K_16   = 16'd16;
	localparam logic [15:0] K_9    = 16'd9;
	localparam logic [15:0] K_221  = 16'd221;
	localparam logic [15:0] K_100  = 16'd100;
	localparam logic [15:0] K_1    = 16'd1;
	localparam logic [15:0] K_1000 = 16'd1000;

	typedef struct packed {
		logic                 start;
		logic [DIV_NUM_W-1:0] num;
		logic [DIV_DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic                 busy;
		logic                 done;
		logic [DIV_NUM_W-1:0] quo;
		logic [DIV_DEN_W-1:0] rem;
	} div_rsp_t;

	typedef enum logic [10:0] {
		ST_IDLE  = 11'b000_0000_0001,
		ST_GCHK  = 11'b000_0000_0010,
		ST_GWAIT = 11'b000_0000_0100,
		ST_QX    = 11'b000_0000_1000,
		ST_QXW   = 11'b000_0001_0000,
		ST_QY    = 11'b000_0010_0000,
		ST_QYW   = 11'b000_0100_0000,
		ST_MUL   = 11'b000_1000_0000,
		ST_DIV3  = 11'b001_0000_0000,
		ST_DIV3W = 11'b010_0000_0000,
		ST_PREP  = 11'b100_0000_0000
	} state_t;

	typedef enum logic [2:0] {
		MT_43,
		MT_169,
		MT_221,
		MT_11,
		MT_NONE
	} match_t;

	localparam logic FUNC_PIX2DISP = 1'b0;
	localparam logic FUNC_DISP2PIX = 1'b1;

	localparam logic ST_OK   = 1'b0;
	localparam logic ST_ZERO = 1'b1;

endpackage

>>> rtl/arc_div.sv
// Aspect ratio converter shared divider: restoring, one quotient bit per cycle.
// Gives quotient and remainder of a DIV_NUM_W by DIV_DEN_W bit division.
// Depends on arc_pkg.
module arc_div import arc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic [DIV_NUM_W-1:0] quo_q;
	logic [DIV_DEN_W-1:0] rem_q;
	logic [DIV_DEN_W-1:0] den_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;

	logic [DIV_DEN_W:0]   sh;
	logic [DIV_DEN_W+1:0] diff;
	logic                 neg;

	assign sh   = {rem_q, quo_q[DIV_NUM_W-1]};
	assign diff = {1'b0, sh} - {2'b00, den_q};
	assign neg  = diff[DIV_DEN_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DIV_NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - DIV_CNT_W'(1);
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.num;
			rem_q <= '0;
			den_q <= req.den;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIV_NUM_W-2:0], ~neg};
			rem_q <= neg ? sh[DIV_DEN_W-1:0] : diff[DIV_DEN_W-1:0];
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;
	assign rsp.rem  = rem_q;

endmodule

>>> rtl/aspect_ratio_converter.sv
// Aspect ratio converter top level: sequencer, shared 32x16 multiplier and
// one shared serial divider used for Euclid steps and all quotients.
// Depends on arc_pkg and arc_div.
//
// Usage:
//   A transaction is taken on a rising edge with start high and busy low;
//   func, ratio_w, ratio_h, frame_width and frame_height are sampled then.
//   One result per transaction: out_w, out_h and status are valid for the
//   single cycle in which done is high; the receiver cannot stall them.
//   A transaction with any zero operand raises done in the next cycle with
//   status set and zero terms; busy stays low. Otherwise every division
//   runs on the shared divider: a Euclid reduction of the frame size, a
//   division of both terms by its result, the multiplies that form the new
//   terms, then a second reduction and division of those terms; a
//   display-to-pixel ratio that matches no standard ratio takes one more
//   division, of the scaled product, before the second reduction.
//   busy falls at the edge that raises done, so the next transaction can be
//   taken at the edge that takes the result; one transaction at a time.
//   Reset (arst_n low) returns the sequencer to idle with done low.
module aspect_ratio_converter import arc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        func,
	input  logic [15:0] ratio_w,
	input  logic [15:0] ratio_h,
	input  logic [15:0] frame_width,
	input  logic [15:0] frame_height,
	output logic        done,
	output logic [31:0] out_w,
	output logic [31:0] out_h,
	output logic        status
);

	state_t      state_q;
	logic [1:0]  mstep_q;
	logic        phase_q;
	logic        done_q;

	logic        func_q;
	logic [15:0] ratio_w_q;
	logic [15:0] ratio_h_q;
	logic [31:0] a_q;
	logic [31:0] b_q;
	logic [31:0] x_q;
	logic [31:0] y_q;
	logic [47:0] num_q;
	logic        status_q;

	div_req_t    div_req;
	div_rsp_t    div_rsp;

	logic        accept;
	logic        any_zero;
	logic [23:0] rw_ext;
	logic [23:0] rh_ext;
	match_t      match;
	logic [15:0] cn;
	logic [15:0] cd;
	logic [31:0] mul_a;
	logic [15:0] mul_b;
	logic [47:0] mul_p;
	logic        mul_last;

	arc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign busy     = (state_q != ST_IDLE);
	assign accept   = start && !busy;
	assign any_zero = (ratio_w == 16'd0) || (ratio_h == 16'd0) ||
		(frame_width == 16'd0) || (frame_height == 16'd0);

	assign rw_ext = {8'd0, ratio_w_q};
	assign rh_ext = {8'd0, ratio_h_q};

	always_comb begin
		if (rw_ext * {8'd0, K_3} == rh_ext * {8'd0, K_4})
			match = MT_43;
		else if (rw_ext * {8'd0, K_9} == rh_ext * {8'd0, K_16})
			match = MT_169;
		else if (rw_ext * {8'd0, K_100} == rh_ext * {8'd0, K_221})
			match = MT_221;
		else if (ratio_w_q == ratio_h_q)
			match = MT_11;
		else
			match = MT_NONE;
	end

	always_comb begin
		case (match)
			MT_43: begin
				cn = K_4;
				cd = K_3;
			end
			MT_169: begin
				cn = K_16;
				cd = K_9;
			end
			MT_221: begin
				cn = K_221;
				cd = K_100;
			end
			default: begin
				cn = K_1;
				cd = K_1;
			end
		endcase
	end

	// step 0: w term, step 1: h term (or num * 1000), step 2: denominator
	always_comb begin
		case (mstep_q)
			2'd0: begin
				mul_a = (func_q == FUNC_PIX2DISP) ? x_q : y_q;
				mul_b = (func_q == FUNC_PIX2DISP || match == MT_NONE) ? ratio_w_q : cn;
			end
			2'd1: begin
				if (func_q == FUNC_PIX2DISP) begin
					mul_a = y_q;
					mul_b = ratio_h_q;
				end else if (match == MT_NONE) begin
					mul_a = num_q[31:0];
					mul_b = K_1000;
				end else begin
					mul_a = x_q;
					mul_b = cd;
				end
			end
			default: begin
				mul_a = x_q;
				mul_b = ratio_h_q;
			end
		endcase
	end

	assign mul_p    = {16'd0, mul_a} * {32'd0, mul_b};
	assign mul_last = (func_q == FUNC_DISP2PIX && match == MT_NONE) ?
		(mstep_q == 2'd2) : (mstep_q == 2'd1);

	always_comb begin
		div_req.start = 1'b0;
		div_req.num   = {16'd0, a_q};
		div_req.den   = b_q;
		case (state_q)
			ST_GCHK: begin
				div_req.start = (b_q != 32'd0);
			end
			ST_QX: begin
				div_req.start = 1'b1;
				div_req.num   = {16'd0, x_q};
				div_req.den   = a_q;
			end
			ST_QY: begin
				div_req.start = 1'b1;
				div_req.num   = {16'd0, y_q};
				div_req.den   = a_q;
			end
			ST_DIV3: begin
				div_req.start = 1'b1;
				div_req.num   = num_q;
				div_req.den   = y_q;
			end
			default: begin
				div_req.start = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			mstep_q <= 2'd0;
			phase_q <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (any_zero) begin
							done_q <= 1'b1;
						end else begin
							phase_q <= 1'b0;
							state_q <= ST_GCHK;
						end
					end
				end
				ST_GCHK: begin
					state_q <= (b_q == 32'd0) ? ST_QX : ST_GWAIT;
				end
				ST_GWAIT: begin
					if (div_rsp.done)
						state_q <= ST_GCHK;
				end
				ST_QX: begin
					state_q <= ST_QXW;
				end
				ST_QXW: begin
					if (div_rsp.done)
						state_q <= ST_QY;
				end
				ST_QY: begin
					state_q <= ST_QYW;
				end
				ST_QYW: begin
					if (div_rsp.done) begin
						if (phase_q) begin
							done_q  <= 1'b1;
							state_q <= ST_IDLE;
						end else begin
							mstep_q <= 2'd0;
							state_q <= ST_MUL;
						end
					end
				end
				ST_MUL: begin
					mstep_q <= mstep_q + 2'd1;
					if (mul_last)
						state_q <= (func_q == FUNC_DISP2PIX && match == MT_NONE) ?
							ST_DIV3 : ST_PREP;
				end
				ST_DIV3: begin
					state_q <= ST_DIV3W;
				end
				ST_DIV3W: begin
					if (div_rsp.done)
						state_q <= ST_PREP;
				end
				ST_PREP: begin
					phase_q <= 1'b1;
					state_q <= ST_GCHK;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					func_q    <= func;
					ratio_w_q <= ratio_w;
					ratio_h_q <= ratio_h;
					a_q       <= {16'd0, frame_width};
					b_q       <= {16'd0, frame_height};
					if (any_zero) begin
						x_q      <= 32'd0;
						y_q      <= 32'd0;
						status_q <= ST_ZERO;
					end else begin
						x_q      <= {16'd0, frame_width};
						y_q      <= {16'd0, frame_height};
						status_q <= ST_OK;
					end
				end
			end
			ST_GCHK: begin
				if (b_q == 32'd0 && a_q == 32'd0)
					a_q <= 32'd1;
			end
			ST_GWAIT: begin
				if (div_rsp.done) begin
					a_q <= b_q;
					b_q <= div_rsp.rem;
				end
			end
			ST_QXW: begin
				if (div_rsp.done)
					x_q <= div_rsp.quo[31:0];
			end
			ST_QYW: begin
				if (div_rsp.done)
					y_q <= div_rsp.quo[31:0];
			end
			ST_MUL: begin
				case (mstep_q)
					2'd0: begin
						num_q <= mul_p;
					end
					2'd1: begin
						if (func_q == FUNC_PIX2DISP) begin
							x_q <= num_q[31:0];
							y_q <= mul_p[31:0];
						end else if (match == MT_NONE) begin
							num_q <= mul_p;
						end else begin
							x_q <= {16'd0, num_q[15:0]};
							y_q <= {16'd0, mul_p[15:0]};
						end
					end
					default: begin
						y_q <= mul_p[31:0];
					end
				endcase
			end
			ST_DIV3W: begin
				if (div_rsp.done) begin
					x_q <= {16'd0, div_rsp.quo[15:0]};
					y_q <= {16'd0, K_1000};
				end
			end
			ST_PREP: begin
				a_q <= x_q;
				b_q <= y_q;
			end
			default: begin
			end
		endcase
	end

	assign done   = done_q;
	assign out_w  = x_q;
	assign out_h  = y_q;
	assign status = status_q;

	a_div_idle_on_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_rsp.busy)
		else $error("divider started while busy");

	a_done_after_txn: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(busy) || $past(start)))
		else $error("result without a transaction");

	a_zero_result: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_ZERO) |-> (out_w == 32'd0 && out_h == 32'd0))
		else $error("error result with nonzero terms");

	a_wait_has_div: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_GWAIT && !div_rsp.busy) |-> div_rsp.done)
		else $error("Euclid wait without divider activity");

endmodule

>>> tb/aspect_ratio_converter_checker.sv
`timescale 1ns / 1ps
// Checker for the aspect ratio converter: predicts each result from the
// accepted transaction and compares it with the strobed output.
// Depends on arc_pkg.
module aspect_ratio_converter_checker import arc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic        func,
	input  logic [15:0] ratio_w,
	input  logic [15:0] ratio_h,
	input  logic [15:0] frame_width,
	input  logic [15:0] frame_height,
	input  logic        done,
	input  logic [31:0] out_w,
	input  logic [31:0] out_h,
	input  logic        status,
	output int          mismatches,
	output int          outstanding
);

	typedef struct packed {
		logic [31:0] w;
		logic [31:0] h;
		logic        st;
	} ratio_result_t;

	ratio_result_t expected_ratios[$];
	ratio_result_t head;

	initial begin
		mismatches = 0;
		outstanding = 0;
	end

	function automatic logic [31:0] euclid_gcd(logic [31:0] a, logic [31:0] b);
		logic [31:0] r;
		if (a == 0)
			return b;
		if (b == 0)
			return a;
		while (b != 0) begin
			r = a % b;
			a = b;
			b = r;
		end
		return a;
	endfunction

	function automatic ratio_result_t convert_ratio(logic fn, logic [15:0] rw_in,
			logic [15:0] rh_in, logic [15:0] fw, logic [15:0] fh);
		ratio_result_t res;
		logic [31:0] wi, hi, g, rw, rh, ow, oh;
		logic [63:0] num, den;
		if (rw_in == 0 || rh_in == 0 || fw == 0 || fh == 0) begin
			res.w = 32'd0;
			res.h = 32'd0;
			res.st = ST_ZERO;
			return res;
		end
		wi = rw_in;
		hi = rh_in;
		g = euclid_gcd({16'd0, fw}, {16'd0, fh});
		rw = fw / g;
		rh = fh / g;
		if (fn == FUNC_PIX2DISP) begin
			ow = rw * wi;
			oh = rh * hi;
		end else begin
			if (wi * K_3 == hi * K_4) begin
				ow = K_4 * rh;
				oh = K_3 * rw;
			end else if (wi * K_9 == hi * K_16) begin
				ow = K_16 * rh;
				oh = K_9 * rw;
			end else if (wi * K_100 == hi * K_221) begin
				ow = K_221 * rh;
				oh = K_100 * rw;
			end else if (wi == hi) begin
				ow = rh;
				oh = rw;
			end else begin
				num = wi;
				num = num * rh * K_1000;
				den = hi;
				den = den * rw;
				num = num / den;
				ow = num[15:0];
				oh = K_1000;
			end
			ow &= 32'h0000_FFFF;
			oh &= 32'h0000_FFFF;
		end
		g = euclid_gcd(ow, oh);
		if (g == 0)
			g = 32'd1;
		res.w = ow / g;
		res.h = oh / g;
		res.st = ST_OK;
		return res;
	endfunction

	task automatic report_mismatch(input string msg);
		mismatches++;
		$display("%0t ns: mismatch: %s", $realtime, msg);
	endtask

	// result check comes first: a transaction taken at this edge cannot be
	// the one answered at this edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (done) begin
				if (expected_ratios.size() == 0) begin
					report_mismatch($sformatf("unexpected result %0d:%0d status %0b",
						out_w, out_h, status));
				end else begin
					head = expected_ratios.pop_front();
					if (out_w !== head.w || out_h !== head.h || status !== head.st)
						report_mismatch($sformatf("got %0d:%0d status %0b, want %0d:%0d status %0b",
							out_w, out_h, status, head.w, head.h, head.st));
				end
			end
			if (start && !busy)
				expected_ratios.push_back(convert_ratio(func, ratio_w, ratio_h,
					frame_width, frame_height));
			outstanding <= expected_ratios.size();
		end
	end

endmodule

>>> tb/aspect_ratio_converter_tb.sv
`timescale 1ns / 1ps
// Testbench top for the aspect ratio converter: clock, reset, directed and
// random transactions, verdict. Depends on arc_pkg, aspect_ratio_converter
// and aspect_ratio_converter_checker.
module aspect_ratio_converter_tb import arc_pkg::*;;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        func = FUNC_PIX2DISP;
	logic [15:0] ratio_w = 16'd0;
	logic [15:0] ratio_h = 16'd0;
	logic [15:0] frame_width = 16'd0;
	logic [15:0] frame_height = 16'd0;
	logic        busy;
	logic        done;
	logic [31:0] out_w;
	logic [31:0] out_h;
	logic        status;
	int          mismatches;
	int          outstanding;

	aspect_ratio_converter dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.func(func),
		.ratio_w(ratio_w),
		.ratio_h(ratio_h),
		.frame_width(frame_width),
		.frame_height(frame_height),
		.done(done),
		.out_w(out_w),
		.out_h(out_h),
		.status(status)
	);

	aspect_ratio_converter_checker ratio_check (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.func(func),
		.ratio_w(ratio_w),
		.ratio_h(ratio_h),
		.frame_width(frame_width),
		.frame_height(frame_height),
		.done(done),
		.out_w(out_w),
		.out_h(out_h),
		.status(status),
		.mismatches(mismatches),
		.outstanding(outstanding)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic int pick_gap(bit quiet);
		if (quiet || $urandom_range(0, 3) != 0)
			return 0;
		return $urandom_range(1, 6);
	endfunction

	task automatic send_request(input logic fn, input logic [15:0] rw, input logic [15:0] rh,
			input logic [15:0] fw, input logic [15:0] fh, input int gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		func <= fn;
		ratio_w <= rw;
		ratio_h <= rh;
		frame_width <= fw;
		frame_height <= fh;
		do @(posedge clk); while (busy);
	endtask

	task automatic pick_frame(output logic [15:0] fw, output logic [15:0] fh);
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 5) begin
			case ($urandom_range(0, 7))
				0: begin fw = 16'd1920; fh = 16'd1080; end
				1: begin fw = 16'd1280; fh = 16'd720; end
				2: begin fw = 16'd720; fh = 16'd480; end
				3: begin fw = 16'd720; fh = 16'd576; end
				4: begin fw = 16'd3840; fh = 16'd2160; end
				5: begin fw = 16'd1440; fh = 16'd1080; end
				6: begin fw = 16'd640; fh = 16'd480; end
				default: begin fw = 16'd4096; fh = 16'd2160; end
			endcase
		end else if (sel < 8) begin
			fw = $urandom_range(1, 65535);
			fh = $urandom_range(1, 65535);
		end else begin
			fw = $urandom_range(1, 64);
			fh = $urandom_range(1, 64);
		end
	endtask

	task automatic pick_request(output logic fn, output logic [15:0] rw, output logic [15:0] rh,
			output logic [15:0] fw, output logic [15:0] fh);
		logic [15:0] k;
		fn = $urandom_range(0, 1) ? FUNC_DISP2PIX : FUNC_PIX2DISP;
		pick_frame(fw, fh);
		if ($urandom_range(0, 1)) begin
			rw = $urandom_range(1, 255);
			rh = $urandom_range(1, 255);
		end else begin
			rw = $urandom_range(1, 65535);
			rh = $urandom_range(1, 65535);
		end
		// standard display ratios with random scale
		if (fn == FUNC_DISP2PIX) begin
			case ($urandom_range(0, 4))
				0: begin k = $urandom_range(1, 16383); rw = k * K_4; rh = k * K_3; end
				1: begin k = $urandom_range(1, 4095); rw = k * K_16; rh = k * K_9; end
				2: begin k = $urandom_range(1, 296); rw = k * K_221; rh = k * K_100; end
				3: begin rw = $urandom_range(1, 65535); rh = rw; end
				default: ;
			endcase
		end
		if ($urandom_range(0, 24) == 0) begin
			case ($urandom_range(0, 3))
				0: rw = 16'd0;
				1: rh = 16'd0;
				2: fw = 16'd0;
				default: fh = 16'd0;
			endcase
		end
	endtask

	initial begin
		logic        fn;
		logic [15:0] rw, rh, fw, fh;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_request(FUNC_PIX2DISP, 16'd1, 16'd1, 16'd1920, 16'd1080, pick_gap(0));
		send_request(FUNC_PIX2DISP, 16'd65535, 16'd65535, 16'd65535, 16'd65535, pick_gap(0));
		send_request(FUNC_PIX2DISP, 16'd65535, 16'd1, 16'd65535, 16'd1, pick_gap(0));
		send_request(FUNC_PIX2DISP, 16'd1, 16'd65535, 16'd1, 16'd65535, pick_gap(0));
		send_request(FUNC_PIX2DISP, 16'd40, 16'd33, 16'd720, 16'd480, pick_gap(0));
		send_request(FUNC_PIX2DISP, 16'd65535, 16'd65534, 16'd46368, 16'd28657, pick_gap(0));
		send_request(FUNC_DISP2PIX, 16'd4, 16'd3, 16'd720, 16'd480, pick_gap(0));
		send_request(FUNC_DISP2PIX, 16'd16, 16'd9, 16'd720, 16'd576, pick_gap(0));
		send_request(FUNC_DISP2PIX, 16'd221, 16'd100, 16'd1920, 16'd1080, pick_gap(0));
		send_request(FUNC_DISP2PIX, 16'd1, 16'd1, 16'd640, 16'd480, pick_gap(0));
		send_request(FUNC_DISP2PIX, 16'd8, 16'd6, 16'd1440, 16'd1080, pick_gap(0));
		send_request(FUNC_DISP2PIX, 16'd65532, 16'd49149, 16'd1, 16'd1, pick_gap(0));
		send_request(FUNC_DISP2PIX, 16'd65535, 16'd65535, 16'd65535, 16'd65534, pick_gap(0));
		send_request(FUNC_DISP2PIX, 16'd5, 16'd4, 16'd1920, 16'd1080, pick_gap(0));
		// quotient wraps past 16 bits, and quotient of zero
		send_request(FUNC_DISP2PIX, 16'd65535, 16'd1, 16'd1, 16'd1, pick_gap(0));
		send_request(FUNC_DISP2PIX, 16'd1, 16'd65535, 16'd1, 16'd1, pick_gap(0));
		// numerator wraps to zero, and a 221 term that wraps
		send_request(FUNC_DISP2PIX, 16'd4, 16'd3, 16'd16383, 16'd16384, pick_gap(0));
		send_request(FUNC_DISP2PIX, 16'd221, 16'd100, 16'd1, 16'd65535, pick_gap(0));
		send_request(FUNC_DISP2PIX, 16'd16, 16'd9, 16'd65535, 16'd65534, pick_gap(0));
		send_request(FUNC_PIX2DISP, 16'd0, 16'd1, 16'd1920, 16'd1080, pick_gap(0));
		send_request(FUNC_DISP2PIX, 16'd4, 16'd0, 16'd1920, 16'd1080, pick_gap(0));
		send_request(FUNC_PIX2DISP, 16'd1, 16'd1, 16'd0, 16'd1080, pick_gap(0));
		send_request(FUNC_DISP2PIX, 16'd16, 16'd9, 16'd1920, 16'd0, pick_gap(0));
		send_request(FUNC_DISP2PIX, 16'd0, 16'd0, 16'd0, 16'd0, pick_gap(0));

		for (int i = 0; i < 500; i++) begin
			pick_request(fn, rw, rh, fw, fh);
			send_request(fn, rw, rh, fw, fh, pick_gap(i >= 440));
		end
		start <= 1'b0;

		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (mismatches == 0)
			$display("aspect_ratio_converter_tb OK");
		else
			$display("aspect_ratio_converter_tb NOT OK");
		$finish;
	end

	initial begin
		#40_000_000;
		$display("timeout");
		$display("aspect_ratio_converter_tb NOT OK");
		$finish;
	end

endmodule
